### rtl/nsp_pkg.sv
`default_nettype none

package nsp_pkg;

    localparam int RX_W      = 8;
    localparam int ADDR_W    = 6;
    localparam int ID_W      = 4;
    localparam int XOR_W     = 16;
    localparam int MASK_W    = 16;
    localparam int ENTRY_W   = 56;
    localparam int TSIZE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 24;
    localparam int ENTRY_NAME_LSB = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BASE = 3'd1;

    localparam logic [RX_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [RX_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [RX_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [RX_W-1:0] CH_CR     = 8'h0D;
    localparam logic [RX_W-1:0] CH_LF     = 8'h0A;
    localparam logic [RX_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [RX_W-1:0] CH_TILDE  = 8'h7E;

    localparam logic [XOR_W-1:0] HEX_BAD = 16'h0F00;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] mask;
    } nsp_match_t;

    // result word, bit 0 first: buf_write, buf_addr, buf_data, sentence_done, sentence_id
    typedef struct packed {
        logic [3:0]        pad;
        logic [ID_W-1:0]   sentence_id;
        logic              sentence_done;
        logic [RX_W-1:0]   buf_data;
        logic [ADDR_W-1:0] buf_addr;
        logic              buf_write;
    } nsp_result_t;

endpackage

`default_nettype wire

### rtl/nsp_table.sv
`default_nettype none

module nsp_table
    import nsp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 7,
    parameter int NAME_CHARS    = 5,
    localparam int NAME_W = 8 * NAME_CHARS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ENTRY_W-1:0]   cfg_data,
    input  wire logic [NAME_W-1:0]    name_chars,
    input  wire logic                 name_too_long,
    output nsp_match_t                match
);

    logic [TSIZE_W-1:0] table_size_reg;
    logic [NAME_W-1:0]  name_reg [TABLE_ENTRIES];
    logic [MASK_W-1:0]  mask_reg [TABLE_ENTRIES];

    logic [63:0]        cfg_ext;
    logic [7:0]         ch;
    logic               zero_seen;
    logic [NAME_W-1:0]  norm_name;
    logic [TSIZE_W-1:0] tsize_eff;

    // entry name ends at its first zero character
    always_comb begin
        cfg_ext   = 64'(cfg_data);
        zero_seen = 1'b0;
        norm_name = '0;
        ch        = '0;
        for (int k = 0; k < NAME_CHARS; k++) begin
            ch = cfg_ext[ENTRY_NAME_LSB + NAME_W - 8*(k+1) +: 8];
            if (ch == 8'h00) begin
                zero_seen = 1'b1;
            end
            if (!zero_seen) begin
                norm_name[NAME_W - 8*(k+1) +: 8] = ch;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= '0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                name_reg[k] <= '0;
                mask_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == CFG_TABLE_SIZE) begin
                table_size_reg <= cfg_data[TSIZE_W-1:0];
            end
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (cfg_index == CFG_ENTRY_BASE + CFG_IDX_W'(k)) begin
                    name_reg[k] <= norm_name;
                    mask_reg[k] <= cfg_data[MASK_W-1:0];
                end
            end
        end
    end

    // parallel compare, lowest entry wins
    always_comb begin
        tsize_eff = (table_size_reg > TSIZE_W'(TABLE_ENTRIES)) ?
                    TSIZE_W'(TABLE_ENTRIES) : table_size_reg;
        match.id   = ID_W'(tsize_eff) + ID_W'(1);
        match.mask = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if ((ID_W'(k) < ID_W'(tsize_eff)) && !name_too_long &&
                (name_reg[k] == name_chars)) begin
                match.id   = ID_W'(k + 1);
                match.mask = mask_reg[k];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/nsp_parser.sv
`default_nettype none

module nsp_parser
    import nsp_pkg::*;
#(
    parameter int BUF_SIZE   = 64,
    parameter int FIELD_BITS = 16,
    parameter int NAME_CHARS = 5,
    localparam int NAME_W = 8 * NAME_CHARS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [RX_W-1:0]   rx_byte,
    input  wire nsp_match_t        match,
    output logic [NAME_W-1:0]      name_chars,
    output logic                   name_too_long,
    output nsp_result_t            result
);

    localparam int WP_W  = $clog2(BUF_SIZE + 1);
    localparam int CNT_W = $clog2(NAME_CHARS + 1);

    typedef enum logic [1:0] {
        PH_BODY,
        PH_HI,
        PH_LO,
        PH_OVER
    } phase_t;

    logic [FIELD_BITS-1:0] onehot_reg, onehot_next;
    logic [FIELD_BITS-1:0] select_reg, select_next;
    logic [WP_W-1:0]       wp_reg, wp_next;
    phase_t                phase_reg, phase_next;
    logic [XOR_W-1:0]      xor_reg, xor_next;
    logic                  bad_reg, bad_next;
    logic [ID_W-1:0]       matched_reg, matched_next;
    logic [NAME_W-1:0]     name_reg, name_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  long_reg, long_next;
    nsp_result_t           result_reg, result_next;

    logic                  active;
    logic                  wp_room;
    logic                  first_field;
    logic [FIELD_BITS-1:0] sel_match;
    logic [XOR_W-1:0]      hex;

    function automatic logic [XOR_W-1:0] hex_value(input logic [RX_W-1:0] c);
        logic [XOR_W-1:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = XOR_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = XOR_W'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = XOR_W'(c - 8'h57);
        end
        return v;
    endfunction

    always_comb begin
        onehot_next  = onehot_reg;
        select_next  = select_reg;
        wp_next      = wp_reg;
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        bad_next     = bad_reg;
        matched_next = matched_reg;
        name_next    = name_reg;
        cnt_next     = cnt_reg;
        long_next    = long_reg;
        result_next  = '0;

        active      = |(onehot_reg & select_reg);
        wp_room     = wp_reg < WP_W'(BUF_SIZE);
        first_field = onehot_reg == FIELD_BITS'(1);
        sel_match   = FIELD_BITS'(match.mask);
        hex         = hex_value(rx_byte);

        case (rx_byte)
            CH_DOLLAR: begin
                onehot_next  = FIELD_BITS'(1);
                select_next  = FIELD_BITS'(1);
                wp_next      = '0;
                phase_next   = PH_BODY;
                xor_next     = '0;
                bad_next     = 1'b0;
                matched_next = '0;
                name_next    = '0;
                cnt_next     = '0;
                long_next    = 1'b0;
            end
            CH_COMMA: begin
                xor_next = xor_reg ^ XOR_W'(rx_byte);
                if (phase_reg != PH_BODY) begin
                    bad_next = 1'b1;
                end
                if (active) begin
                    if (wp_room) begin
                        result_next.buf_write = 1'b1;
                        result_next.buf_addr  = ADDR_W'(wp_reg);
                        wp_next = wp_reg + WP_W'(1);
                    end
                    if (first_field) begin
                        matched_next = match.id;
                        select_next  = sel_match;
                        if (!sel_match[0]) begin
                            wp_next = '0;
                        end
                    end
                end
                onehot_next = onehot_reg << 1;
            end
            CH_STAR: begin
                if (phase_reg != PH_BODY) begin
                    bad_next = 1'b1;
                end else begin
                    phase_next = PH_HI;
                end
            end
            CH_CR, CH_LF: begin
                if (active && wp_room) begin
                    result_next.buf_write = 1'b1;
                    result_next.buf_addr  = ADDR_W'(wp_reg);
                end
                if ((onehot_reg > (select_reg >> 1)) && (matched_reg != '0) &&
                    (xor_reg == '0) && !bad_reg) begin
                    result_next.sentence_done = 1'b1;
                    result_next.sentence_id   = matched_reg;
                end
                onehot_next = '0;
            end
            default: begin
                if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE) begin
                    case (phase_reg)
                        PH_BODY: begin
                            xor_next = xor_reg ^ XOR_W'(rx_byte);
                            if (active) begin
                                if (wp_room) begin
                                    result_next.buf_write = 1'b1;
                                    result_next.buf_addr  = ADDR_W'(wp_reg);
                                    result_next.buf_data  = rx_byte;
                                    wp_next = wp_reg + WP_W'(1);
                                end
                                if (first_field) begin
                                    if (cnt_reg < CNT_W'(NAME_CHARS)) begin
                                        for (int k = 0; k < NAME_CHARS; k++) begin
                                            if (cnt_reg == CNT_W'(k)) begin
                                                name_next[NAME_W - 8*(k+1) +: 8] = rx_byte;
                                            end
                                        end
                                        cnt_next = cnt_reg + CNT_W'(1);
                                    end else begin
                                        long_next = 1'b1;
                                    end
                                end
                                if (wp_next >= WP_W'(BUF_SIZE)) begin
                                    select_next = '0;
                                end
                            end
                        end
                        PH_HI: begin
                            xor_next   = xor_reg ^ {hex[XOR_W-5:0], 4'b0000};
                            phase_next = PH_LO;
                        end
                        PH_LO: begin
                            xor_next   = xor_reg ^ hex;
                            phase_next = PH_OVER;
                        end
                        default: begin
                            bad_next = 1'b1;
                        end
                    endcase
                end else begin
                    bad_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            onehot_reg  <= '0;
            select_reg  <= '0;
            wp_reg      <= '0;
            phase_reg   <= PH_BODY;
            xor_reg     <= '0;
            bad_reg     <= 1'b0;
            matched_reg <= '0;
            name_reg    <= '0;
            cnt_reg     <= '0;
            long_reg    <= 1'b0;
        end else if (step) begin
            onehot_reg  <= onehot_next;
            select_reg  <= select_next;
            wp_reg      <= wp_next;
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            bad_reg     <= bad_next;
            matched_reg <= matched_next;
            name_reg    <= name_next;
            cnt_reg     <= cnt_next;
            long_reg    <= long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign name_chars    = name_reg;
    assign name_too_long = long_reg;
    assign result        = result_reg;

endmodule

`default_nettype wire

### rtl/nmea_sentence_parser_core.sv
`default_nettype none

// NMEA 0183 sentence parser. Takes one received byte per word on the s_ side and
// returns one result word per byte on the m_ side: a field buffer write (address,
// character or 0 terminator) and, on CR or LF, the sentence report (table entry
// number, or table size + 1 for an unknown name). A byte goes through an input
// register, one pass of parse logic with a parallel compare of the sentence name
// against all table entries, and the result register, so the block takes one byte
// every cycle unless m_tready holds back the result. Write the table only while
// the stream is idle.
module nmea_sentence_parser_core
    import nsp_pkg::*;
#(
    parameter int BUF_SIZE      = 64,
    parameter int FIELD_BITS    = 16,
    parameter int TABLE_ENTRIES = 7,
    parameter int NAME_CHARS    = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [RX_W-1:0]      s_tdata,   // rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // buf_write, buf_addr, buf_data, sentence_done, sentence_id, zero fill
    output logic [OUT_W-1:0]          m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ENTRY_W-1:0]   cfg_data
);

    localparam int NAME_W = 8 * NAME_CHARS;

    logic              in_valid_reg;
    logic [RX_W-1:0]   in_byte_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              step;
    logic [NAME_W-1:0] name_chars;
    logic              name_too_long;
    nsp_match_t        match;
    nsp_result_t       result;

    assign advance   = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    nsp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_CHARS    (NAME_CHARS)
    ) u_table (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .name_chars    (name_chars),
        .name_too_long (name_too_long),
        .match         (match)
    );

    nsp_parser #(
        .BUF_SIZE   (BUF_SIZE),
        .FIELD_BITS (FIELD_BITS),
        .NAME_CHARS (NAME_CHARS)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .match         (match),
        .name_chars    (name_chars),
        .name_too_long (name_too_long),
        .result        (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result;

endmodule

`default_nettype wire

### rtl/nsp_checker.sv
`default_nettype none

module nsp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // no write means zero address and data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[14:1] == 14'd0)
        else $error("buffer address or data set without a write");

    // id shows only with a reported sentence, and is never zero then
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] == (m_tdata[19:16] != 4'd0)))
        else $error("sentence id does not agree with sentence done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:20] == 4'd0)
        else $error("fill bits of result word not zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or dropped");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind nmea_sentence_parser_core nsp_checker u_nsp_checker (.*);

`default_nettype wire
